/* src/rgbpfc_pkg.sv */
// Shared types, format codes and arithmetic constants for the RGB24 pixel
// format converter. No dependencies; used by every module in src/.
`default_nettype none

package rgbpfc_pkg;

   // Output format codes held in the format register
   typedef enum logic [2:0] {
      FMT_YUY2   = 3'd0,
      FMT_UYVY   = 3'd1,
      FMT_RGB32  = 3'd2,
      FMT_RGB565 = 3'd3,
      FMT_RGB555 = 3'd4
   } fmt_type;

   localparam int unsigned FMT_W  = 3;
   localparam int unsigned COMP_W = 8;    // one color or YUV component
   localparam int unsigned HUND_W = 15;   // value scaled by 100, always below 32768
   localparam int unsigned QUO_W  = 9;    // value / 100, at most 260

   // Conversion coefficients in hundredths
   localparam logic [HUND_W-1:0] KY_R   = 15'd29;
   localparam logic [HUND_W-1:0] KY_G   = 15'd59;
   localparam logic [HUND_W-1:0] KY_B   = 15'd14;
   localparam logic [HUND_W-1:0] KU_R   = 15'd14;
   localparam logic [HUND_W-1:0] KU_G   = 15'd29;
   localparam logic [HUND_W-1:0] KU_B   = 15'd43;
   localparam logic [HUND_W-1:0] KV_R   = 15'd36;
   localparam logic [HUND_W-1:0] KV_G   = 15'd29;
   localparam logic [HUND_W-1:0] KV_B   = 15'd7;
   localparam logic [HUND_W-1:0] OFFSET = 15'd12800;

   // Clamp limits
   localparam logic [QUO_W-1:0] Y_MAX = 9'd235;
   localparam logic [QUO_W-1:0] C_MAX = 9'd240;

   // floor(x / 100) = (x * 5243) >> 19, exact for x below 32768
   localparam int unsigned     RECIP_W     = 13;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
   localparam int unsigned     RECIP_SHIFT = 19;
   localparam int unsigned     PROD_W      = HUND_W + RECIP_W;

   // Input request payload
   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
      logic              row_end;
   } req_type;

   // Result payload
   typedef struct packed {
      logic [31:0] pixel_word;
      logic        row_done;
   } rsp_type;

   // Middle pipeline stage: hundredths-scaled YUV plus the source pixel
   typedef struct packed {
      logic [HUND_W-1:0] y100;
      logic [HUND_W-1:0] u100;
      logic [HUND_W-1:0] v100;
      req_type           pix;
   } hund_type;

   // Divide a hundredths value by 100 with truncation
   function automatic logic [QUO_W-1:0] div100(input logic [HUND_W-1:0] x);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(x) * PROD_W'(RECIP_100);
      return prod[RECIP_SHIFT +: QUO_W];
   endfunction

   // Clamp a quotient to an upper limit
   function automatic logic [COMP_W-1:0] clamp_hi(input logic [QUO_W-1:0] q,
                                                  input logic [QUO_W-1:0] hi);
      logic [QUO_W-1:0] c;
      c = (q > hi) ? hi : q;
      return c[COMP_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* src/rgbpfc_csc.sv */
// Color space sums: Y, U and V of one pixel scaled by 100.
// Depends on rgbpfc_pkg.
`default_nettype none

module rgbpfc_csc (
   input  wire  rgbpfc_pkg::req_type  pix,
   output rgbpfc_pkg::hund_type       hund
);

   logic [rgbpfc_pkg::HUND_W-1:0] r_w, g_w, b_w;

   assign r_w = rgbpfc_pkg::HUND_W'(pix.red);
   assign g_w = rgbpfc_pkg::HUND_W'(pix.green);
   assign b_w = rgbpfc_pkg::HUND_W'(pix.blue);

   // U and V stay positive over the full input range, so the 15-bit
   // wrap-around sums land on the exact value
   always_comb begin
      hund.y100 = rgbpfc_pkg::KY_R * r_w + rgbpfc_pkg::KY_G * g_w
                + rgbpfc_pkg::KY_B * b_w;
      hund.u100 = rgbpfc_pkg::OFFSET + rgbpfc_pkg::KU_B * b_w
                - rgbpfc_pkg::KU_R * r_w - rgbpfc_pkg::KU_G * g_w;
      hund.v100 = rgbpfc_pkg::OFFSET + rgbpfc_pkg::KV_R * r_w
                - rgbpfc_pkg::KV_G * g_w - rgbpfc_pkg::KV_B * b_w;
      hund.pix  = pix;
   end

endmodule

`default_nettype wire

/* src/rgbpfc_pack.sv */
// Scale-down, clamp, YUV pairing and output word packing, with the pair
// latch. Depends on rgbpfc_pkg.
`default_nettype none

module rgbpfc_pack (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              adv,        // stage hands its pixel on
   input  wire                              cfg_clear,  // format register written
   input  wire  [rgbpfc_pkg::FMT_W-1:0]     format,
   input  wire  rgbpfc_pkg::hund_type       hund,
   output logic                             emit,
   output rgbpfc_pkg::rsp_type              rsp
);

   logic                            pair_half_ff, pair_half_in;
   logic [rgbpfc_pkg::COMP_W-1:0]   held_luma_ff, held_luma_in;
   logic [rgbpfc_pkg::COMP_W-1:0]   held_cb_ff, held_cb_in;
   logic [rgbpfc_pkg::COMP_W-1:0]   held_cr_ff, held_cr_in;
   logic [rgbpfc_pkg::COMP_W-1:0]   y, u, v, cu, cv;
   logic [rgbpfc_pkg::COMP_W:0]     sum_u, sum_v;
   logic                            yuv_mode;

   // Divide by 100 and clamp
   assign y = rgbpfc_pkg::clamp_hi(rgbpfc_pkg::div100(hund.y100), rgbpfc_pkg::Y_MAX);
   assign u = rgbpfc_pkg::clamp_hi(rgbpfc_pkg::div100(hund.u100), rgbpfc_pkg::C_MAX);
   assign v = rgbpfc_pkg::clamp_hi(rgbpfc_pkg::div100(hund.v100), rgbpfc_pkg::C_MAX);

   // Floor average of the pair's chroma
   assign sum_u = {1'b0, held_cb_ff} + {1'b0, u};
   assign sum_v = {1'b0, held_cr_ff} + {1'b0, v};
   assign cu    = sum_u[rgbpfc_pkg::COMP_W:1];
   assign cv    = sum_v[rgbpfc_pkg::COMP_W:1];

   assign yuv_mode = (format == rgbpfc_pkg::FMT_YUY2) || (format == rgbpfc_pkg::FMT_UYVY);

   // Output word for the current format
   always_comb begin
      rsp.row_done = hund.pix.row_end;
      case (format)
         rgbpfc_pkg::FMT_YUY2:   rsp.pixel_word = {cv, y, cu, held_luma_ff};
         rgbpfc_pkg::FMT_UYVY:   rsp.pixel_word = {y, cv, held_luma_ff, cu};
         rgbpfc_pkg::FMT_RGB32:  rsp.pixel_word = {8'h00, hund.pix.red,
                                                   hund.pix.green, hund.pix.blue};
         rgbpfc_pkg::FMT_RGB565: rsp.pixel_word = {16'h0000, hund.pix.red[7:3],
                                                   hund.pix.green[7:2], hund.pix.blue[7:3]};
         rgbpfc_pkg::FMT_RGB555: rsp.pixel_word = {16'h0000, 1'b0, hund.pix.red[7:3],
                                                   hund.pix.green[7:3], hund.pix.blue[7:3]};
         default:                rsp.pixel_word = '0;
      endcase
   end

   // Pair tracking and emit decision
   always_comb begin
      emit         = 1'b0;
      pair_half_in = pair_half_ff;
      held_luma_in = held_luma_ff;
      held_cb_in   = held_cb_ff;
      held_cr_in   = held_cr_ff;
      if (adv) begin
         case (format)
            rgbpfc_pkg::FMT_YUY2, rgbpfc_pkg::FMT_UYVY: begin
               if (pair_half_ff) begin
                  pair_half_in = 1'b0;
                  emit         = 1'b1;
               end else if (!hund.pix.row_end) begin
                  // first of pair: latch it
                  pair_half_in = 1'b1;
                  held_luma_in = y;
                  held_cb_in   = u;
                  held_cr_in   = v;
               end else begin
                  // odd last pixel of the row is dropped
                  pair_half_in = 1'b0;
               end
            end
            rgbpfc_pkg::FMT_RGB32, rgbpfc_pkg::FMT_RGB565, rgbpfc_pkg::FMT_RGB555: begin
               pair_half_in = 1'b0;
               emit         = 1'b1;
            end
            default: begin
               pair_half_in = 1'b0;
            end
         endcase
      end
      if (cfg_clear) begin
         pair_half_in = 1'b0;
      end
   end

   // Pair flag
   always_ff @(posedge clock) begin
      if (reset) begin
         pair_half_ff <= 1'b0;
      end else begin
         pair_half_ff <= pair_half_in;
      end
   end

   // Held first-of-pair values; only read while the pair flag is set
   always_ff @(posedge clock) begin
      held_luma_ff <= held_luma_in;
      held_cb_ff   <= held_cb_in;
      held_cr_ff   <= held_cr_in;
   end

   // A format write always discards a half-filled pair
   a_cfg_clears_pair: assert property (@(posedge clock) disable iff (reset)
      cfg_clear |=> !pair_half_ff)
      else $error("pair flag survived a format write");

   // RGB and unused formats never leave a pair open
   a_rgb_no_pair: assert property (@(posedge clock) disable iff (reset)
      adv && !yuv_mode |=> !pair_half_ff)
      else $error("pair flag set outside YUV formats");

   // A YUV word is only produced on the second pixel of a pair
   a_yuv_emit_second: assert property (@(posedge clock) disable iff (reset)
      emit && yuv_mode |-> pair_half_ff)
      else $error("YUV word emitted without a held first pixel");

endmodule

`default_nettype wire

/* src/rgb24_pixel_format_converter_unit.sv */
// Top level of the RGB24 pixel format converter: handshake, pipeline
// registers and the format register. Depends on rgbpfc_pkg, rgbpfc_csc and
// rgbpfc_pack.
//
// Usage:
//   req_*  carries one RGB888 source pixel per request with a row-end flag.
//   rsp_*  carries one 32-bit display word; row_done marks the row's last word.
//   csr_*  writes the output format (YUY2, UYVY, RGB32, RGB565, RGB555);
//          a write also drops any half-built YUV pair. Write only while idle.
// Pipeline: input register, sums register (Y/U/V scaled by 100), result
//   register. An accepted request passes through them in that order and
//   shows its word on rsp_* from the result register.
// Throughput: one request per cycle when not stalled. RGB formats give one
//   word per request; YUV formats give one word per two requests, and an
//   odd last pixel of a row gives none. Codes 5 to 7 swallow every request.
// Stalls: when rsp_ready is low the result register holds its word and each
//   stage behind it fills in turn; req_ready drops only once all three
//   registers are full. Stages move independently, so a bubble is squeezed
//   out without losing a cycle.
// Reset: synchronous, active high; empties the pipeline, selects YUY2 and
//   clears the pair flag.
`default_nettype none

module rgb24_pixel_format_converter_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  rgbpfc_pkg::req_type            req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output rgbpfc_pkg::rsp_type                  rsp_data,
   input  wire                                  csr_wr_en,
   input  wire  [rgbpfc_pkg::FMT_W-1:0]         csr_wr_data
);

   logic [rgbpfc_pkg::FMT_W-1:0] format_ff, format_in;
   rgbpfc_pkg::req_type          s1_ff, s1_in;
   logic                         s1_valid_ff, s1_valid_in;
   rgbpfc_pkg::hund_type         s2_ff, s2_in, hund;
   logic                         s2_valid_ff, s2_valid_in;
   rgbpfc_pkg::rsp_type          rsp_ff, rsp_in, pack_rsp;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         out_free, s2_free, s2_adv, s1_adv, req_acc, emit;

   // Stage flow control
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_adv    = s2_valid_ff && out_free;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_adv    = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s2_free;
   assign req_acc   = req_valid && req_ready;

   // Color space sums between input and middle registers
   rgbpfc_csc u_csc (
      .pix  (s1_ff),
      .hund (hund)
   );

   // Scale, pair and pack between middle and result registers
   rgbpfc_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .adv       (s2_adv),
      .cfg_clear (csr_wr_en),
      .format    (format_ff),
      .hund      (s2_ff),
      .emit      (emit),
      .rsp       (pack_rsp)
   );

   // Next-state values for all stages
   always_comb begin
      format_in    = csr_wr_en ? csr_wr_data : format_ff;
      s1_in        = req_acc ? req_data : s1_ff;
      s1_valid_in  = req_acc || (s1_valid_ff && !s1_adv);
      s2_in        = s1_adv ? hund : s2_ff;
      s2_valid_in  = s2_free ? s1_valid_ff : s2_valid_ff;
      rsp_in       = (s2_adv && emit) ? pack_rsp : rsp_ff;
      rsp_valid_in = out_free ? (s2_adv && emit) : rsp_valid_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= rgbpfc_pkg::FMT_YUY2;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         format_ff    <= format_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A new result only comes from a pixel that sat in the middle stage
   a_rsp_from_s2: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff))
      else $error("result appeared without a middle-stage pixel");

   // A blocked input stage keeps its pixel
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_free |=> s1_valid_ff && $stable(s1_ff))
      else $error("input stage lost a pixel while blocked");

   // Input is only refused when every stage is full
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && s2_valid_ff && rsp_valid_ff)
      else $error("request refused with room in the pipeline");

endmodule

`default_nettype wire

/* bench/rgb24_pixel_format_converter_unit_tb.sv */
// Self-checking bench for rgb24_pixel_format_converter_unit: a directed block
// and then random rows of pixels under every real format and some unused codes, with idle and stall gaps.
// Depends on rgbpfc_pkg and the converter RTL in src/.
`default_nettype none

module rgb24_pixel_format_converter_unit_tb;

   localparam int          RANDOM_ITEMS = 1150;
   localparam int          CYCLE_LIMIT  = 500000;
   localparam int          SETTLE       = 8;      // three pipeline stages, with margin
   localparam int          SHOW_ERRORS  = 10;
   localparam int          LUMA_CEIL    = 235;
   localparam int          CHROMA_CEIL  = 240;
   localparam logic [2:0]  FMT_SPARE_LO = 3'd5;   // unused codes swallow requests
   localparam logic [2:0]  FMT_SPARE_HI = 3'd7;

   logic                          clock;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_ready;
   rgbpfc_pkg::req_type           req_data    = '0;
   logic                          rsp_valid;
   logic                          rsp_ready   = 1'b0;
   rgbpfc_pkg::rsp_type           rsp_data;
   logic                          csr_wr_en   = 1'b0;
   logic [rgbpfc_pkg::FMT_W-1:0]  csr_wr_data = '0;

   rgb24_pixel_format_converter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // pending pixels and the display words they should produce
   rgbpfc_pkg::req_type pixel_queue[$];
   rgbpfc_pkg::rsp_type expected_words[$];

   int pushed_count   = 0;
   int accepted_count = 0;
   int words_checked  = 0;
   int error_count    = 0;
   int format_writes  = 0;
   int cycle_count    = 0;
   int send_idle      = 0;   // 0: sender never idles, 1: random gaps
   int recv_idle      = 0;   // 0: receiver never stalls, 1: random stalls
   bit req_taken      = 1'b0;

   // converter state as the bench sees it
   logic [2:0] out_format = rgbpfc_pkg::FMT_YUY2;
   logic [7:0] held_y     = '0;
   logic [7:0] held_u     = '0;
   logic [7:0] held_v     = '0;
   bit         pair_open  = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap(input int level);
      int roll;
      roll = $urandom_range(99);
      if (level == 0 || roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(3, 1);
      return $urandom_range(30, 6);
   endfunction

   // hundredths value to a component: truncate, negatives to zero, clamp high
   function automatic logic [7:0] scale_clamp(input int hund, input int ceiling);
      int q;
      if (hund < 0)
         return 8'd0;
      q = hund / 100;
      if (q > ceiling)
         q = ceiling;
      return 8'(q);
   endfunction

   // Expected display word for one accepted request, if it makes one
   function automatic void convert_pixel(input rgbpfc_pkg::req_type px);
      int                  ri, gi, bi;
      logic [7:0]          y, u, v;
      logic [8:0]          sum_u, sum_v;
      logic [31:0]         word;
      rgbpfc_pkg::rsp_type want;
      ri = px.red;
      gi = px.green;
      bi = px.blue;
      y = scale_clamp(29 * ri + 59 * gi + 14 * bi, LUMA_CEIL);
      u = scale_clamp(12800 - 14 * ri - 29 * gi + 43 * bi, CHROMA_CEIL);
      v = scale_clamp(12800 + 36 * ri - 29 * gi - 7 * bi, CHROMA_CEIL);
      case (out_format)
         rgbpfc_pkg::FMT_YUY2, rgbpfc_pkg::FMT_UYVY: begin
            if (!pair_open) begin
               // odd last pixel of a row is dropped, otherwise latched
               if (!px.row_end) begin
                  held_y    = y;
                  held_u    = u;
                  held_v    = v;
                  pair_open = 1'b1;
               end
               return;
            end
            pair_open = 1'b0;
            sum_u = {1'b0, held_u} + {1'b0, u};
            sum_v = {1'b0, held_v} + {1'b0, v};
            if (out_format == rgbpfc_pkg::FMT_YUY2)
               word = {sum_v[8:1], y, sum_u[8:1], held_y};
            else
               word = {y, sum_v[8:1], held_y, sum_u[8:1]};
         end
         rgbpfc_pkg::FMT_RGB32: begin
            pair_open = 1'b0;
            word = {8'd0, px.red, px.green, px.blue};
         end
         rgbpfc_pkg::FMT_RGB565: begin
            pair_open = 1'b0;
            word = {16'd0, px.red[7:3], px.green[7:2], px.blue[7:3]};
         end
         rgbpfc_pkg::FMT_RGB555: begin
            pair_open = 1'b0;
            word = {17'd0, px.red[7:3], px.green[7:3], px.blue[7:3]};
         end
         default: begin
            pair_open = 1'b0;
            return;
         end
      endcase
      want.pixel_word = word;
      want.row_done   = px.row_end;
      expected_words.push_back(want);
   endfunction

   task automatic note_error(input string what, input rgbpfc_pkg::rsp_type want,
                             input rgbpfc_pkg::rsp_type got);
      error_count++;
      if (error_count <= SHOW_ERRORS)
         $display("%s at cycle %0d: expected word %08h done %0b, got word %08h done %0b",
                  what, cycle_count, want.pixel_word, want.row_done,
                  got.pixel_word, got.row_done);
   endtask

   // request driver: holds the payload until taken, then waits its gap
   int send_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0 || pixel_queue.size() == 0) begin
            req_valid <= 1'b0;
            if (send_gap > 0)
               send_gap--;
         end else begin
            req_valid <= 1'b1;
            req_data  <= pixel_queue.pop_front();
            send_gap  = pick_gap(send_idle);
         end
      end
   end

   // result side back-pressure
   int stall_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap(recv_idle);
      end
   end

   // monitor: predict on each accepted request, check each accepted word
   always @(posedge clock) begin
      cycle_count++;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            accepted_count++;
            convert_pixel(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (expected_words.size() == 0) begin
               note_error("unexpected word", '0, rsp_data);
            end else begin
               rgbpfc_pkg::rsp_type want;
               want = expected_words.pop_front();
               if (rsp_data.pixel_word !== want.pixel_word ||
                   rsp_data.row_done !== want.row_done)
                  note_error("word mismatch", want, rsp_data);
            end
         end
      end
   end

   task automatic push_pixel(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic last);
      rgbpfc_pkg::req_type px;
      px.red     = r;
      px.green   = g;
      px.blue    = b;
      px.row_end = last;
      pixel_queue.push_back(px);
      pushed_count++;
   endtask

   // wait until every request is taken and every word seen
   task automatic wait_drained(input bit settle);
      while (accepted_count != pushed_count || expected_words.size() != 0)
         @(negedge clock);
      if (settle)
         repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_format(input logic [2:0] code);
      wait_drained(1'b1);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= code;
      out_format  = code;
      pair_open   = 1'b0;
      format_writes++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // components lean toward the extremes
   function automatic logic [7:0] pick_component();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10)
         return 8'h00;
      if (roll < 20)
         return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   // mostly whole rows of random length, some loose pixels
   task automatic push_traffic(input int n);
      int left, row_len, k;
      left = n;
      while (left > 0) begin
         if ($urandom_range(99) < 15) begin
            push_pixel(pick_component(), pick_component(), pick_component(),
                       1'($urandom_range(1)));
            left--;
         end else begin
            row_len = $urandom_range(16, 1);
            if (row_len > left)
               row_len = left;
            for (k = 0; k < row_len; k++)
               push_pixel(pick_component(), pick_component(), pick_component(),
                          k == row_len - 1);
            left -= row_len;
         end
      end
   endtask

   initial begin : stimulus
      int         phase, n, random_items;
      logic [2:0] code;
      phase = 0;
      random_items = 0;
      while (reset)
         @(negedge clock);

      // YUY2 out of reset: clamped white, row end on the second of a pair,
      // an odd pixel at row end, then a pair left half built
      push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      push_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
      push_pixel(8'h00, 8'h00, 8'hFF, 1'b1);
      push_pixel(8'h00, 8'hFF, 8'h00, 1'b1);
      push_pixel(8'h00, 8'hFF, 8'hFF, 1'b0);
      push_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
      push_pixel(8'hFF, 8'hFF, 8'h00, 1'b0);

      // format write drops the open pair
      write_format(rgbpfc_pkg::FMT_UYVY);
      push_pixel(8'd18, 8'd200, 8'd77, 1'b0);
      push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      push_pixel(8'h00, 8'h00, 8'h00, 1'b1);

      write_format(rgbpfc_pkg::FMT_RGB32);
      push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      push_pixel(8'hA5, 8'h5A, 8'h3C, 1'b0);

      write_format(rgbpfc_pkg::FMT_RGB565);
      push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      push_pixel(8'h07, 8'h03, 8'hF8, 1'b0);

      write_format(rgbpfc_pkg::FMT_RGB555);
      push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      push_pixel(8'h07, 8'h07, 8'hF8, 1'b1);

      write_format(FMT_SPARE_HI);
      push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      push_pixel(8'h01, 8'h02, 8'h03, 1'b0);

      // random phases; the first five walk through every real format
      while (random_items < RANDOM_ITEMS) begin
         if (phase < 5)
            code = 3'(phase);
         else if ($urandom_range(99) < 8)
            code = 3'($urandom_range(FMT_SPARE_HI, FMT_SPARE_LO));
         else
            code = 3'($urandom_range(rgbpfc_pkg::FMT_RGB555, rgbpfc_pkg::FMT_YUY2));
         write_format(code);
         send_idle = ($urandom_range(3) != 0);
         recv_idle = ($urandom_range(3) != 0);
         if (code >= FMT_SPARE_LO) begin
            push_traffic(8);
         end else begin
            n = $urandom_range(150, 40);
            push_traffic(n / 2);
            // sender holds off until the block has emptied
            wait_drained(1'b0);
            push_traffic(n - n / 2);
            random_items += n;
         end
         phase++;
      end

      wait_drained(1'b1);
      $display("Covered %0d requests and %0d checked words over %0d format writes,",
               accepted_count, words_checked, format_writes);
      $display("  with %0d mismatches and %0d words still awaited.",
               error_count, expected_words.size());
      if (error_count == 0 && expected_words.size() == 0)
         $display("PASS rgb24_pixel_format_converter_unit");
      else
         $display("FAIL rgb24_pixel_format_converter_unit");
      $finish;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("Timed out after %0d cycles", cycle_count);
      $display("FAIL rgb24_pixel_format_converter_unit");
      $finish;
   end

endmodule

`default_nettype wire
